### hw/rtl/cabf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cabf_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned ACT_W  = 5;

  // BCD digit adjust constants
  localparam logic [4:0] DIGIT_MAX  = 5'd9;
  localparam logic [4:0] DEC_ADJ    = 5'd6;
  localparam logic [5:0] NIBBLE_MAX = 6'd15;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADC  = 5'd0,
    ACT_SBC  = 5'd1,
    ACT_CMP  = 5'd2,
    ACT_AND  = 5'd3,
    ACT_ORA  = 5'd4,
    ACT_EOR  = 5'd5,
    ACT_ASL  = 5'd6,
    ACT_LSR  = 5'd7,
    ACT_ROL  = 5'd8,
    ACT_ROR  = 5'd9,
    ACT_INC  = 5'd10,
    ACT_DEC  = 5'd11,
    ACT_BIT  = 5'd12,
    ACT_BITI = 5'd13,
    ACT_TSB  = 5'd14,
    ACT_TRB  = 5'd15,
    ACT_LOAD = 5'd16
  } action_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic              carry_in;
    logic              decimal_mode;
    logic              negative_in;
    logic              overflow_in;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              negative_out;
    logic              overflow_out;
    logic              zero_out;
    logic              carry_out;
  } alu_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/cabf_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cabf_in_if
  import cabf_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [DATA_W-1:0] operand_a;
  logic [DATA_W-1:0] operand_b;
  logic              carry_in;
  logic              decimal_mode;
  logic              negative_in;
  logic              overflow_in;

  modport source (
    output valid, action, operand_a, operand_b, carry_in, decimal_mode,
           negative_in, overflow_in,
    input  ready
  );

  modport sink (
    input  valid, action, operand_a, operand_b, carry_in, decimal_mode,
           negative_in, overflow_in,
    output ready
  );
endinterface

interface cabf_out_if
  import cabf_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result;
  logic              negative_out;
  logic              overflow_out;
  logic              zero_out;
  logic              carry_out;

  modport source (
    output valid, result, negative_out, overflow_out, zero_out, carry_out,
    input  ready
  );

  modport sink (
    input  valid, result, negative_out, overflow_out, zero_out, carry_out,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/cpu_alu_bcd_flags.sv
// 65C02-style ALU with BCD add/subtract and flag update.
//
// Channels: in_ch carries one operation (code, operands, incoming C/D/N/V);
// out_ch carries the result byte and the new N, V, Z and C. Both use a
// valid/ready handshake; a transfer happens on a rising edge with both high.
//
// Path: an operation transferred in is held in the input register,
// evaluated by one pass of byte-wide logic and captured in the result
// register when that register has room, and its result is offered from
// the result register.
// Throughput: one operation per cycle; the input and result registers form
// a two-entry pipeline, so a new operation is taken every cycle while the
// receiver keeps taking results.
//
// Reset (rst, synchronous, active high) empties both registers; there is no
// other state. When the receiver stalls, the result register holds its
// transfer, the input register fills behind it, and in_ch.ready then drops
// until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module cpu_alu_bcd_flags
  import cabf_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  cabf_in_if.sink      in_ch,
  cabf_out_if.source   out_ch
);

  // Input register
  logic     s1_valid;
  alu_req_t s1_req;
  logic     s1_ready;

  // Result register
  logic     out_valid;
  alu_rsp_t out_rsp;
  logic     s2_ready;

  alu_rsp_t rsp;

  assign s2_ready    = ~out_valid | out_ch.ready;
  assign s1_ready    = ~s1_valid | s2_ready;
  assign in_ch.ready = s1_ready;

  // Advance the input register whenever it is empty or drains this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) begin
      s1_req.action       <= in_ch.action;
      s1_req.operand_a    <= in_ch.operand_a;
      s1_req.operand_b    <= in_ch.operand_b;
      s1_req.carry_in     <= in_ch.carry_in;
      s1_req.decimal_mode <= in_ch.decimal_mode;
      s1_req.negative_in  <= in_ch.negative_in;
      s1_req.overflow_in  <= in_ch.overflow_in;
    end
  end

  cabf_core u_core (
    .req (s1_req),
    .rsp (rsp)
  );

  // Capture the result when there is room; drop the valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      out_rsp <= rsp;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.result       = out_rsp.result;
  assign out_ch.negative_out = out_rsp.negative_out;
  assign out_ch.overflow_out = out_rsp.overflow_out;
  assign out_ch.zero_out     = out_rsp.zero_out;
  assign out_ch.carry_out    = out_rsp.carry_out;

  // Reset leaves the pipeline empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !s1_valid && !out_valid)
    else $error("pipeline not empty after reset");

  // An accepted operation always lands in the input register
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> s1_valid)
    else $error("accepted operation lost at input register");

  // An evaluated operation moves on to the result register when there is room
  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready |=> out_valid)
    else $error("operation lost between input and result registers");

  // A stalled result blocks new input only once the input register is full
  a_stall_backs_up: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready && s1_valid |-> !in_ch.ready)
    else $error("input taken while both registers are full");

endmodule

`default_nettype wire

### hw/rtl/cabf_core.sv
`timescale 1ns / 1ps
`default_nettype none

module cabf_core
  import cabf_pkg::*;
(
  input  var alu_req_t req,
  output var alu_rsp_t rsp
);

  logic [7:0] a;
  logic [7:0] b;
  logic       c;
  logic       borrow;
  logic [8:0] add_bin;
  logic [8:0] sub_bin;
  logic [8:0] cmp_diff;
  logic [4:0] add_lo;
  logic [5:0] add_hi;
  logic       add_lo_adj;
  logic [4:0] add_lo_fix;
  logic [5:0] add_hi_inc;
  logic [5:0] add_hi_fix;
  logic [5:0] sub_lo;
  logic [5:0] sub_hi;
  logic [5:0] sub_lo_fix;
  logic [5:0] sub_hi_dec;
  logic [5:0] sub_hi_fix;

  assign a      = req.operand_a;
  assign b      = req.operand_b;
  assign c      = req.carry_in;
  assign borrow = ~req.carry_in;

  // Binary paths
  assign add_bin  = {1'b0, a} + {1'b0, b} + {8'd0, c};
  assign sub_bin  = {1'b0, a} - {1'b0, b} - {8'd0, borrow};
  assign cmp_diff = {1'b0, a} - {1'b0, b};

  // Decimal add: adjust each digit that passes nine
  assign add_lo     = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c};
  assign add_hi     = {2'b0, a[7:4]} + {2'b0, b[7:4]};
  assign add_lo_adj = (add_lo > DIGIT_MAX);
  assign add_lo_fix = add_lo_adj ? add_lo + DEC_ADJ : add_lo;
  assign add_hi_inc = add_hi + {5'd0, add_lo_adj};
  assign add_hi_fix = (add_hi_inc > {1'b0, DIGIT_MAX}) ? add_hi_inc + {1'b0, DEC_ADJ}
                                                       : add_hi_inc;

  // Decimal subtract: a digit that went negative takes a further six off
  assign sub_lo     = {2'b0, a[3:0]} - {2'b0, b[3:0]} - {5'd0, borrow};
  assign sub_hi     = {2'b0, a[7:4]} - {2'b0, b[7:4]};
  assign sub_lo_fix = sub_lo[5] ? sub_lo - {1'b0, DEC_ADJ} : sub_lo;
  assign sub_hi_dec = sub_hi - {5'd0, sub_lo[5]};
  assign sub_hi_fix = sub_hi_dec[5] ? sub_hi_dec - {1'b0, DEC_ADJ} : sub_hi_dec;

  always_comb begin
    logic [7:0] r;
    logic       n;
    logic       v;
    logic       cf;
    logic       nz_from_r;
    r         = b;
    n         = req.negative_in;
    v         = req.overflow_in;
    cf        = req.carry_in;
    nz_from_r = 1'b1;
    case (action_t'(req.action))
      ACT_ADC: begin
        v = ~(a[7] ^ b[7]) & (a[7] ^ add_bin[7]);
        if (req.decimal_mode) begin
          cf = (add_hi_fix > NIBBLE_MAX);
          r  = {add_hi_fix[3:0], add_lo_fix[3:0]};
        end else begin
          cf = add_bin[8];
          r  = add_bin[7:0];
        end
      end
      ACT_SBC: begin
        v  = (a[7] ^ b[7]) & (a[7] ^ sub_bin[7]);
        cf = ~sub_bin[8];
        r  = req.decimal_mode ? {sub_hi_fix[3:0], sub_lo_fix[3:0]} : sub_bin[7:0];
      end
      ACT_CMP: begin
        r  = cmp_diff[7:0];
        cf = ~cmp_diff[8];
      end
      ACT_AND: r = a & b;
      ACT_ORA: r = a | b;
      ACT_EOR: r = a ^ b;
      ACT_ASL: begin
        cf = b[7];
        r  = {b[6:0], 1'b0};
      end
      ACT_LSR: begin
        cf = b[0];
        r  = {1'b0, b[7:1]};
      end
      ACT_ROL: begin
        cf = b[7];
        r  = {b[6:0], c};
      end
      ACT_ROR: begin
        cf = b[0];
        r  = {c, b[7:1]};
      end
      ACT_INC: r = b + 8'd1;
      ACT_DEC: r = b - 8'd1;
      ACT_BIT: begin
        n         = b[7];
        v         = b[6];
        nz_from_r = 1'b0;
      end
      ACT_BITI: nz_from_r = 1'b0;
      ACT_TSB: begin
        r         = b | a;
        nz_from_r = 1'b0;
      end
      ACT_TRB: begin
        r         = b & ~a;
        nz_from_r = 1'b0;
      end
      default: r = b;  // load, and the unused codes behave as load
    endcase

    rsp.result       = r;
    rsp.overflow_out = v;
    rsp.carry_out    = cf;
    if (nz_from_r) begin
      rsp.negative_out = r[7];
      rsp.zero_out     = (r == 8'd0);
    end else begin
      rsp.negative_out = n;
      rsp.zero_out     = ((a & b) == 8'd0);
    end
  end

endmodule

`default_nettype wire

### test/cpu_alu_bcd_flags_tb.sv
`timescale 1ns / 1ps

module cpu_alu_bcd_flags_tb;
  import cabf_pkg::*;

  // Action codes past load are not named in the package. They must behave as a load.
  localparam logic [ACT_W-1:0] ACT_UNDEF_FIRST = 5'd17;
  localparam logic [ACT_W-1:0] ACT_UNDEF_LAST  = 5'd31;

  localparam int WATCHDOG_LIMIT = 2000; // cycles with no transfer on either channel
  localparam int STALL_CYCLES   = 64;   // long receiver hold-off, fills the pipeline
  localparam int DRAIN_TAIL     = 8;    // settling margin after the final drain
  localparam int RAND_PHASE_OPS = 460;

  logic clk = 1'b0;
  logic rst;

  cabf_in_if  in_ch ();
  cabf_out_if out_ch ();

  cpu_alu_bcd_flags i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // Operations waiting to be driven, and flag/result predictions waiting for
  // their transfer on the output channel (oldest first).
  alu_req_t pending_ops[$];
  alu_rsp_t predicted_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_asked   = 0;  // bumped by the stimulus, served by the receiver
  int stall_given   = 0;
  int stall_left    = 0;
  int ops_accepted  = 0;
  int results_seen  = 0;
  int err_cnt       = 0;
  int quiet_cycles  = 0;
  logic op_taken;         // an operation transferred at the last rising edge

  // ---------------------------------------------------------------------------
  // Predictor: 65C02 ALU, one result per operation, no state.
  // ---------------------------------------------------------------------------
  function automatic alu_rsp_t alu_predict(alu_req_t op);
    logic [7:0] a, b, r;
    logic [8:0] sum;
    logic       cin, c, n, v, nz_from_r;
    int         lo, hi, borrow;
    alu_rsp_t   rsp;
    a         = op.operand_a;
    b         = op.operand_b;
    cin       = op.carry_in;
    c         = cin;
    n         = op.negative_in;
    v         = op.overflow_in;
    r         = b;
    nz_from_r = 1'b1;
    case (op.action)
      ACT_ADC: begin
        sum = {1'b0, a} + {1'b0, b} + {8'b0, cin};
        // V always comes from the binary sum, even in decimal mode.
        v = ~(a[7] ^ b[7]) & (a[7] ^ sum[7]);
        if (!op.decimal_mode) begin
          r = sum[7:0];
          c = sum[8];
        end else begin
          // Nibble-wise adjust, applied as is to invalid digits too.
          lo = a[3:0];
          lo = lo + b[3:0] + cin;
          hi = a[7:4];
          hi = hi + b[7:4];
          if (lo > 9) begin
            lo = lo + 6;
            hi = hi + 1;
          end
          if (hi > 9) hi = hi + 6;
          c = (hi > 15);
          r = {hi[3:0], lo[3:0]};
        end
      end
      ACT_SBC: begin
        sum = {1'b0, a} - {1'b0, b} - {8'b0, ~cin};
        v   = (a[7] ^ b[7]) & (a[7] ^ sum[7]);
        // Borrow-out from the binary difference, decimal or not.
        c   = ({1'b0, a} >= ({1'b0, b} + {8'b0, ~cin}));
        if (!op.decimal_mode) begin
          r = sum[7:0];
        end else begin
          borrow = cin ? 0 : 1;
          lo = a[3:0];
          lo = lo - b[3:0] - borrow;
          hi = a[7:4];
          hi = hi - b[7:4];
          if (lo < 0) begin
            lo = lo - 6;
            hi = hi - 1;
          end
          if (hi < 0) hi = hi - 6;
          r = {hi[3:0], lo[3:0]};
        end
      end
      ACT_CMP: begin
        r = a - b;
        c = (a >= b);
      end
      ACT_AND: r = a & b;
      ACT_ORA: r = a | b;
      ACT_EOR: r = a ^ b;
      ACT_ASL: begin
        r = {b[6:0], 1'b0};
        c = b[7];
      end
      ACT_LSR: begin
        r = {1'b0, b[7:1]};
        c = b[0];
      end
      ACT_ROL: begin
        r = {b[6:0], cin};
        c = b[7];
      end
      ACT_ROR: begin
        r = {cin, b[7:1]};
        c = b[0];
      end
      ACT_INC: r = b + 8'd1;
      ACT_DEC: r = b - 8'd1;
      ACT_BIT: begin
        n         = b[7];
        v         = b[6];
        nz_from_r = 1'b0;
      end
      ACT_BITI: nz_from_r = 1'b0;
      ACT_TSB: begin
        r         = b | a;
        nz_from_r = 1'b0;
      end
      ACT_TRB: begin
        r         = b & ~a;
        nz_from_r = 1'b0;
      end
      default: r = b;  // load, and every undefined code
    endcase
    rsp.result       = r;
    rsp.negative_out = nz_from_r ? r[7] : n;
    rsp.overflow_out = v;
    rsp.zero_out     = nz_from_r ? (r == 8'h00) : ((a & b) == 8'h00);
    rsp.carry_out    = c;
    return rsp;
  endfunction

  function automatic alu_req_t make_op(logic [ACT_W-1:0] act, logic [7:0] a, logic [7:0] b,
                                       logic c, logic d, logic n, logic v);
    alu_req_t op;
    op.action       = act;
    op.operand_a    = a;
    op.operand_b    = b;
    op.carry_in     = c;
    op.decimal_mode = d;
    op.negative_in  = n;
    op.overflow_in  = v;
    return op;
  endfunction

  // Operand bytes: half valid BCD or corner values, the other half fully random.
  function automatic logic [7:0] pick_byte();
    logic [31:0] rnd;
    logic [7:0]  val;
    rnd = $urandom;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0:       val = 8'h00;
          1:       val = 8'hFF;
          2:       val = 8'h7F;
          3:       val = 8'h80;
          4:       val = 8'h99;
          default: val = 8'h01;
        endcase
      end
      1, 2, 3: val = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      default: val = rnd[7:0];
    endcase
    return val;
  endfunction

  function automatic alu_req_t random_op();
    alu_req_t    op;
    logic [31:0] rnd;
    int          sel;
    rnd = $urandom;
    sel = $urandom_range(0, 99);
    // Weight add/subtract up: the decimal adjust is where the flags get subtle.
    if (sel < 5)
      op.action = 5'($urandom_range(ACT_UNDEF_FIRST, ACT_UNDEF_LAST));
    else if (sel < 35)
      op.action = 5'($urandom_range(ACT_ADC, ACT_SBC));
    else
      op.action = 5'($urandom_range(ACT_ADC, ACT_LOAD));
    op.operand_a    = pick_byte();
    op.operand_b    = pick_byte();
    op.carry_in     = rnd[0];
    op.decimal_mode = rnd[1];
    op.negative_in  = rnd[2];
    op.overflow_in  = rnd[3];
    return op;
  endfunction

  task automatic flag_error(input string what);
    if (err_cnt < 10) $display("ERROR at %0t: %s", $time, what);
    err_cnt++;
  endtask

  // Hold the stimulus until the queue is empty, nothing is on the input channel
  // and every prediction has been matched.
  task automatic wait_drain();
    while (pending_ops.size() != 0 || in_ch.valid || ops_accepted != results_seen)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: advance to the next operation once the current one is transferred.
  // Idle slots are drawn only while the channel is free, so an offered
  // operation stays put until the block takes it.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_ops
    alu_req_t op;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || op_taken) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        op = pending_ops.pop_front();
        in_ch.action       <= op.action;
        in_ch.operand_a    <= op.operand_a;
        in_ch.operand_b    <= op.operand_b;
        in_ch.carry_in     <= op.carry_in;
        in_ch.decimal_mode <= op.decimal_mode;
        in_ch.negative_in  <= op.negative_in;
        in_ch.overflow_in  <= op.overflow_in;
        in_ch.valid        <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a long hold-off on request so that the
  // result and input registers both fill and the block drops its input ready.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : accept_results
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (stall_asked != stall_given) begin
      out_ch.ready <= 1'b0;
      stall_given  <= stall_given + 1;
      stall_left   <= STALL_CYCLES;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest prediction, then
  // predict for an operation transferred on the same edge. Also run the
  // watchdog on cycles with no transfer at all.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    alu_req_t seen;
    alu_rsp_t got, want;
    logic     in_xfer, out_xfer;
    if (rst) begin
      op_taken <= 1'b0;
    end else begin
      in_xfer  = in_ch.valid && in_ch.ready;
      out_xfer = out_ch.valid && out_ch.ready;
      op_taken <= in_xfer;

      if (out_xfer) begin
        got.result       = out_ch.result;
        got.negative_out = out_ch.negative_out;
        got.overflow_out = out_ch.overflow_out;
        got.zero_out     = out_ch.zero_out;
        got.carry_out    = out_ch.carry_out;
        if (predicted_results.size() == 0) begin
          flag_error($sformatf("unexpected result %02h N%0b V%0b Z%0b C%0b",
                               got.result, got.negative_out, got.overflow_out,
                               got.zero_out, got.carry_out));
        end else begin
          want = predicted_results.pop_front();
          results_seen <= results_seen + 1;
          if (got.result !== want.result || got.negative_out !== want.negative_out ||
              got.overflow_out !== want.overflow_out || got.zero_out !== want.zero_out ||
              got.carry_out !== want.carry_out)
            flag_error($sformatf(
              "expected %02h N%0b V%0b Z%0b C%0b, got %02h N%0b V%0b Z%0b C%0b",
              want.result, want.negative_out, want.overflow_out, want.zero_out,
              want.carry_out, got.result, got.negative_out, got.overflow_out,
              got.zero_out, got.carry_out));
        end
      end

      if (in_xfer) begin
        seen.action       = in_ch.action;
        seen.operand_a    = in_ch.operand_a;
        seen.operand_b    = in_ch.operand_b;
        seen.carry_in     = in_ch.carry_in;
        seen.decimal_mode = in_ch.decimal_mode;
        seen.negative_in  = in_ch.negative_in;
        seen.overflow_in  = in_ch.overflow_in;
        predicted_results.push_back(alu_predict(seen));
        ops_accepted <= ops_accepted + 1;
      end

      if (in_xfer || out_xfer) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("cpu_alu_bcd_flags_tb: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. Everything here but the reset release runs on rising edges;
  // driver and receiver read these variables on falling edges.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.action        = ACT_ADC;
    in_ch.operand_a     = 8'h00;
    in_ch.operand_b     = 8'h00;
    in_ch.carry_in      = 1'b0;
    in_ch.decimal_mode  = 1'b0;
    in_ch.negative_in   = 1'b0;
    in_ch.overflow_in   = 1'b0;
    out_ch.ready        = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // Directed: every operation, operand extremes and the flag corner cases.
    // Binary add: carry out with zero result, then signed overflow.
    pending_ops.push_back(make_op(ACT_ADC, 8'hFF, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_ops.push_back(make_op(ACT_ADC, 8'h7F, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0));
    // Decimal add: 99 + 1 wraps to 00 with carry; invalid digits FF + FF + 1.
    pending_ops.push_back(make_op(ACT_ADC, 8'h99, 8'h01, 1'b0, 1'b1, 1'b0, 1'b0));
    pending_ops.push_back(make_op(ACT_ADC, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
    // Subtract: binary borrow, signed overflow, decimal 00 - 01 -> 99, and
    // decimal with an invalid low digit and an incoming borrow.
    pending_ops.push_back(make_op(ACT_SBC, 8'h00, 8'h01, 1'b1, 1'b0, 1'b0, 1'b0));
    pending_ops.push_back(make_op(ACT_SBC, 8'h80, 8'h01, 1'b1, 1'b0, 1'b0, 1'b0));
    pending_ops.push_back(make_op(ACT_SBC, 8'h00, 8'h01, 1'b1, 1'b1, 1'b0, 1'b0));
    pending_ops.push_back(make_op(ACT_SBC, 8'h0A, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1));
    pending_ops.push_back(make_op(ACT_CMP, 8'h10, 8'h20, 1'b1, 1'b0, 1'b0, 1'b1));
    pending_ops.push_back(make_op(ACT_AND, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
    pending_ops.push_back(make_op(ACT_ORA, 8'h80, 8'h01, 1'b0, 1'b0, 1'b0, 1'b1));
    pending_ops.push_back(make_op(ACT_EOR, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0));
    pending_ops.push_back(make_op(ACT_ASL, 8'h00, 8'h80, 1'b0, 1'b0, 1'b1, 1'b0));
    pending_ops.push_back(make_op(ACT_LSR, 8'h00, 8'h01, 1'b0, 1'b0, 1'b1, 1'b1));
    pending_ops.push_back(make_op(ACT_ROL, 8'h00, 8'h80, 1'b1, 1'b0, 1'b0, 1'b0));
    pending_ops.push_back(make_op(ACT_ROR, 8'h00, 8'h01, 1'b1, 1'b0, 1'b0, 1'b0));
    pending_ops.push_back(make_op(ACT_INC, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1));
    pending_ops.push_back(make_op(ACT_DEC, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
    // BIT takes N and V from the memory byte; BIT immediate, TSB and TRB keep
    // the incoming N and V and set Z from the AND of the operands.
    pending_ops.push_back(make_op(ACT_BIT, 8'h3F, 8'hC0, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_ops.push_back(make_op(ACT_BITI, 8'h3F, 8'hC0, 1'b1, 1'b0, 1'b1, 1'b1));
    pending_ops.push_back(make_op(ACT_TSB, 8'h0F, 8'h81, 1'b0, 1'b0, 1'b1, 1'b0));
    pending_ops.push_back(make_op(ACT_TRB, 8'hFF, 8'hF0, 1'b1, 1'b0, 1'b0, 1'b1));
    pending_ops.push_back(make_op(ACT_LOAD, 8'hFF, 8'h80, 1'b1, 1'b1, 1'b0, 1'b1));
    // Undefined codes fall back to load.
    pending_ops.push_back(make_op(ACT_UNDEF_FIRST, 8'h55, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1));
    pending_ops.push_back(make_op(ACT_UNDEF_LAST, 8'hAA, 8'h7F, 1'b0, 1'b1, 1'b1, 1'b0));
    wait_drain();

    // Random, mostly busy sender against a mostly stalled receiver.
    send_idle_pct = 29;
    recv_idle_pct = 84;
    repeat (RAND_PHASE_OPS) pending_ops.push_back(random_op());
    wait_drain();

    // Swap: the sender is the slow side.
    send_idle_pct = 84;
    recv_idle_pct = 29;
    repeat (RAND_PHASE_OPS) pending_ops.push_back(random_op());
    wait_drain();

    // Full rate on both sides; open with a long receiver hold-off while the
    // sender keeps offering, so the block backs up and stalls its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_asked   = stall_asked + 1;
    repeat (RAND_PHASE_OPS) pending_ops.push_back(random_op());
    wait_drain();

    repeat (DRAIN_TAIL) @(posedge clk);
    if (err_cnt == 0 && predicted_results.size() == 0) begin
      $display("cpu_alu_bcd_flags_tb: done, clean");
    end else begin
      $display("cpu_alu_bcd_flags_tb: done, errors");
    end
    $finish;
  end

endmodule
